@@ sv/qnc_pkg.sv @@
package qnc_pkg;

   localparam int CodeWidth  = 64;
   localparam int CoordWidth = 32;
   localparam int LevelWidth = 5;
   localparam int IndexWidth = 4;
   localparam int ShiftWidth = 7;

   localparam logic [LevelWidth-1:0] MaxLevel = LevelWidth'(30);
   localparam logic [IndexWidth-1:0] LastStep = IndexWidth'(8);

   // neighbor offset along one axis, in units of one level-deep cell
   typedef enum logic [1:0] {
      OFF_MINUS = 2'd0,
      OFF_ZERO  = 2'd1,
      OFF_PLUS  = 2'd2
   } offset_type;

   // one neighbor to encode, handed from the sequencer to the encoder
   typedef struct packed {
      logic [CoordWidth-1:0] x_base;
      logic [CoordWidth-1:0] y_base;
      logic [CoordWidth-1:0] stride;
      logic [CodeWidth-1:0]  mask;
      offset_type            x_off;
      offset_type            y_off;
      logic [IndexWidth-1:0] index;
      logic                  last;
   } work_type;

   typedef struct packed {
      logic [IndexWidth-1:0] neighbor_index;
      logic [CodeWidth-1:0]  range_low;
      logic [CodeWidth-1:0]  range_high;
      logic                  last_range;
   } rsp_word_type;

   // gather every other bit of the code, starting at bit lane
   function automatic logic [CoordWidth-1:0] pick_lane(input logic [CodeWidth-1:0] code,
                                                       input logic lane);
      logic [CoordWidth-1:0] v;
      v = '0;
      for (int i = 0; i < CoordWidth; i++) begin
         v[i] = lane ? code[2*i+1] : code[2*i];
      end
      return v;
   endfunction

   // interleave x into the even bits and y into the odd bits
   function automatic logic [CodeWidth-1:0] interleave(input logic [CoordWidth-1:0] x,
                                                       input logic [CoordWidth-1:0] y);
      logic [CodeWidth-1:0] c;
      c = '0;
      for (int i = 0; i < CoordWidth; i++) begin
         c[2*i]   = x[i];
         c[2*i+1] = y[i];
      end
      return c;
   endfunction

endpackage

@@ sv/qnc_if.sv @@
interface qnc_req_if;
   import qnc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CodeWidth-1:0]  cell_code;
   logic [LevelWidth-1:0] level;

   modport source (output valid, output cell_code, output level, input ready);
   modport sink   (input valid, input cell_code, input level, output ready);
   modport monitor(input valid, input cell_code, input level, input ready);
endinterface

interface qnc_rsp_if;
   import qnc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [IndexWidth-1:0] neighbor_index;
   logic [CodeWidth-1:0]  range_low;
   logic [CodeWidth-1:0]  range_high;
   logic                  last_range;

   modport source (output valid, output neighbor_index, output range_low,
                   output range_high, output last_range, input ready);
   modport sink   (input valid, input neighbor_index, input range_low,
                   input range_high, input last_range, output ready);
   modport monitor(input valid, input neighbor_index, input range_low,
                   input range_high, input last_range, input ready);
endinterface

@@ sv/qnc_seq.sv @@
module qnc_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [qnc_pkg::CodeWidth-1:0]  cell_code,
   input  logic [qnc_pkg::LevelWidth-1:0] level,
   input  logic                           advance,
   output logic                           work_valid,
   output qnc_pkg::work_type              work
);
   import qnc_pkg::*;

   logic                  busy_ff, busy_in;
   logic [IndexWidth-1:0] step_ff, step_in;
   offset_type            xoff_ff, xoff_in;
   offset_type            yoff_ff, yoff_in;
   logic [CoordWidth-1:0] x_ff, y_ff, stride_ff;
   logic [CodeWidth-1:0]  mask_ff;

   logic                  load;
   logic                  at_last;
   logic [LevelWidth-1:0] lvl;
   logic [ShiftWidth-1:0] mask_shift;
   logic [LevelWidth:0]   stride_shift;

   assign at_last  = (step_ff == LastStep);
   assign in_ready = !busy_ff || (advance && at_last);
   assign load     = in_valid && in_ready;

   // level 31 saturates to the deepest supported level
   assign lvl          = (level > MaxLevel) ? MaxLevel : level;
   assign mask_shift   = ShiftWidth'(CodeWidth) - ShiftWidth'({lvl, 1'b0});
   assign stride_shift = (LevelWidth+1)'(CoordWidth) - (LevelWidth+1)'(lvl);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      xoff_in = xoff_ff;
      yoff_in = yoff_ff;
      if (load) begin
         busy_in = 1'b1;
         step_in = '0;
         xoff_in = OFF_MINUS;
         yoff_in = OFF_MINUS;
      end else if (advance) begin
         if (at_last) begin
            busy_in = 1'b0;
            step_in = '0;
         end else begin
            step_in = step_ff + IndexWidth'(1);
         end
         case (yoff_ff)
            OFF_MINUS: yoff_in = OFF_ZERO;
            OFF_ZERO:  yoff_in = OFF_PLUS;
            default: begin
               yoff_in = OFF_MINUS;
               case (xoff_ff)
                  OFF_MINUS: xoff_in = OFF_ZERO;
                  OFF_ZERO:  xoff_in = OFF_PLUS;
                  default:   xoff_in = OFF_MINUS;
               endcase
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         xoff_ff <= OFF_MINUS;
         yoff_ff <= OFF_MINUS;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         xoff_ff <= xoff_in;
         yoff_ff <= yoff_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff      <= pick_lane(cell_code, 1'b0);
         y_ff      <= pick_lane(cell_code, 1'b1);
         stride_ff <= (lvl == '0) ? '0 : (CoordWidth'(1) << stride_shift);
         mask_ff   <= (lvl == '0) ? '0 : ({CodeWidth{1'b1}} << mask_shift);
      end
   end

   assign work_valid   = busy_ff;
   assign work.x_base  = x_ff;
   assign work.y_base  = y_ff;
   assign work.stride  = stride_ff;
   assign work.mask    = mask_ff;
   assign work.x_off   = xoff_ff;
   assign work.y_off   = yoff_ff;
   assign work.index   = step_ff;
   assign work.last    = at_last;

endmodule

@@ sv/qnc_encode.sv @@
module qnc_encode (
   input  qnc_pkg::work_type     work,
   output qnc_pkg::rsp_word_type word
);
   import qnc_pkg::*;

   logic [CoordWidth-1:0] xi, yi;
   logic [CodeWidth-1:0]  code;

   // x moves with the offset; the stored y bits are inverted, so they move against it
   always_comb begin
      case (work.x_off)
         OFF_MINUS: xi = work.x_base - work.stride;
         OFF_PLUS:  xi = work.x_base + work.stride;
         default:   xi = work.x_base;
      endcase
      case (work.y_off)
         OFF_MINUS: yi = work.y_base + work.stride;
         OFF_PLUS:  yi = work.y_base - work.stride;
         default:   yi = work.y_base;
      endcase
   end

   assign code = interleave(xi, yi);

   assign word.neighbor_index = work.index;
   assign word.range_low      = code & work.mask;
   assign word.range_high     = code | ~work.mask;
   assign word.last_range     = work.last;

endmodule

@@ sv/quadtree_neighbor_cell_ranges.sv @@
//  channel    | dir | handshake          | word
//  -----------+-----+--------------------+------------------------------------------------
//  req_chan   | in  | valid/ready        | cell_code[63:0], level[4:0]
//  rsp_chan   | out | valid/ready        | neighbor_index[3:0], range_low[63:0],
//             |     |                    | range_high[63:0], last_range
//
//  One request word yields nine response words, one per cycle while the response side does
//  not stall; the step counter in qnc_seq steps through the nine words.
//  A request is taken in the same cycle its predecessor's ninth word leaves the sequencer.
//  Synchronous active-high reset empties the sequencer and the output register.
//  A response stall holds the output register and freezes the step counter.
module quadtree_neighbor_cell_ranges (
   input logic         clock,
   input logic         reset,
   qnc_req_if.sink     req_chan,
   qnc_rsp_if.source   rsp_chan
);
   import qnc_pkg::*;

   logic         work_valid;
   work_type     work;
   rsp_word_type enc_word;
   logic         advance;

   rsp_word_type rsp_word_ff;
   logic         rsp_valid_ff, rsp_valid_in;

   // sequencer moves when the output register is empty or being drained
   assign advance = work_valid && (!rsp_valid_ff || rsp_chan.ready);

   qnc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .cell_code  (req_chan.cell_code),
      .level      (req_chan.level),
      .advance    (advance),
      .work_valid (work_valid),
      .work       (work)
   );

   qnc_encode u_encode (
      .work (work),
      .word (enc_word)
   );

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= enc_word;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.neighbor_index = rsp_word_ff.neighbor_index;
   assign rsp_chan.range_low      = rsp_word_ff.range_low;
   assign rsp_chan.range_high     = rsp_word_ff.range_high;
   assign rsp_chan.last_range     = rsp_word_ff.last_range;

endmodule

@@ sv/qnc_checker.sv @@
module qnc_checker (
   input logic        clock,
   input logic        reset,
   qnc_req_if.sink    req_chan,
   qnc_rsp_if.source  rsp_chan
);
   import qnc_pkg::*;

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=>
         rsp_chan.valid && $stable(rsp_chan.neighbor_index) &&
         $stable(rsp_chan.range_low) && $stable(rsp_chan.range_high))
      else $error("response word changed while stalled");

   // the ninth neighbor and only it closes a request
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.last_range == (rsp_chan.neighbor_index == LastStep)))
      else $error("last_range does not match neighbor index");

   // the low bound's bits are all present in the high bound
   a_range_order: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> ((rsp_chan.range_low & rsp_chan.range_high) == rsp_chan.range_low))
      else $error("range_low not contained in range_high");

   // a taken request keeps the block busy for the following cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request taken again right after acceptance");

endmodule

bind quadtree_neighbor_cell_ranges qnc_checker u_qnc_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);
